// ===== rtl/core/ipsp_pkg.sv =====
// ----------------------------------------------------------------------------
// IPS patch parser package
// Shared constants, result codes and the command record passed from the
// byte parser to the result sequencer.
// ----------------------------------------------------------------------------
package ipsp_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [2:0]  HDR_LEN  = 3'd5;
    localparam logic [2:0]  OFF_LEN  = 3'd3;
    localparam logic [2:0]  SIZE_LEN = 3'd2;
    localparam logic [23:0] EOF_MARK = 24'h454F46;
    localparam int          TDATA_W  = 96;

    // result kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_FILL  = 2'd1;
    localparam logic [1:0] KIND_FIN   = 2'd2;

    // end status codes
    localparam logic [1:0] ST_EOF      = 2'd0;
    localparam logic [1:0] ST_BOUNDARY = 2'd1;
    localparam logic [1:0] ST_BAD_HDR  = 2'd2;
    localparam logic [1:0] ST_TRUNC    = 2'd3;

    // one queue entry: an optional write/fill, then an optional finish
    typedef struct packed {
        logic        has_item;
        logic [1:0]  kind;
        logic [23:0] addr;
        logic [15:0] run;
        logic [7:0]  val;
        logic        has_fin;
        logic [1:0]  status;
        logic [15:0] recs;
        logic [24:0] end_addr;
    } t_cmd;

    // expected "PATCH" header bytes
    function automatic logic [7:0] hdr_byte(input logic [2:0] idx);
        logic [7:0] res;
        case (idx)
            3'd0:    res = 8'h50;
            3'd1:    res = 8'h41;
            3'd2:    res = 8'h54;
            3'd3:    res = 8'h43;
            3'd4:    res = 8'h48;
            default: res = 8'h00;
        endcase
        return res;
    endfunction

endpackage

// ===== rtl/core/ipsp_front.sv =====
// ----------------------------------------------------------------------------
// IPS patch byte parser
// Walks the header and record fields one byte per beat and pushes one command
// per byte that produces results.
// ----------------------------------------------------------------------------
module ipsp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_byte,
    input  logic          i_final,
    input  logic          i_full,
    output logic          o_push,
    output ipsp_pkg::t_cmd o_cmd
);
    import ipsp_pkg::*;

    typedef enum logic [6:0] {
        PH_HEADER = 7'b0000001,
        PH_OFFSET = 7'b0000010,
        PH_SIZE   = 7'b0000100,
        PH_COUNT  = 7'b0001000,
        PH_FILL   = 7'b0010000,
        PH_DATA   = 7'b0100000,
        PH_DONE   = 7'b1000000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_idx, n_idx;
    logic [23:0] r_start, n_start;
    logic [15:0] r_size, n_size;
    logic [15:0] r_left, n_left;
    logic [23:0] r_waddr, n_waddr;
    logic [15:0] r_count, n_count;
    logic [24:0] r_last_end, n_last_end;

    logic        accept;
    logic        fin;
    logic [1:0]  fin_st;
    logic        complete;
    logic [2:0]  idx_inc;
    logic [15:0] size_shift;
    logic [23:0] start_shift;
    logic [15:0] left_dec;
    t_cmd        cmd;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_phase    = r_phase;
        n_idx      = r_idx;
        n_start    = r_start;
        n_size     = r_size;
        n_left     = r_left;
        n_waddr    = r_waddr;
        fin        = 1'b0;
        fin_st     = ST_EOF;
        complete   = 1'b0;
        cmd        = '0;
        idx_inc    = r_idx + 3'd1;
        size_shift  = {r_size[7:0], i_byte};
        start_shift = {r_start[15:0], i_byte};
        left_dec    = r_left - 16'd1;

        case (r_phase)
            PH_HEADER: begin
                if (i_byte != hdr_byte(r_idx)) begin
                    fin    = 1'b1;
                    fin_st = ST_BAD_HDR;
                end else if (idx_inc == HDR_LEN) begin
                    n_idx   = '0;
                    n_phase = PH_OFFSET;
                    fin     = i_final;
                    fin_st  = ST_BOUNDARY;
                end else begin
                    n_idx  = idx_inc;
                    fin    = i_final;
                    fin_st = ST_BAD_HDR;
                end
            end
            PH_OFFSET: begin
                n_start = start_shift;
                fin_st  = ST_TRUNC;
                if (idx_inc == OFF_LEN) begin
                    n_idx = '0;
                    if (start_shift == EOF_MARK) begin
                        fin    = 1'b1;
                        fin_st = ST_EOF;
                    end else begin
                        n_phase = PH_SIZE;
                        fin     = i_final;
                    end
                end else begin
                    n_idx = idx_inc;
                    fin   = i_final;
                end
            end
            PH_SIZE, PH_COUNT: begin
                n_size = size_shift;
                fin    = i_final;
                fin_st = ST_TRUNC;
                if (idx_inc == SIZE_LEN) begin
                    n_idx = '0;
                    if (r_phase == PH_COUNT) begin
                        n_phase = PH_FILL;
                    end else if (size_shift == 16'd0) begin
                        n_phase = PH_COUNT;
                    end else begin
                        n_left  = size_shift;
                        n_waddr = r_start;
                        n_phase = PH_DATA;
                    end
                end else begin
                    n_idx = idx_inc;
                end
            end
            PH_FILL: begin
                cmd.has_item = 1'b1;
                cmd.kind     = KIND_FILL;
                cmd.addr     = r_start;
                cmd.run      = r_size;
                cmd.val      = i_byte;
                complete     = 1'b1;
                fin          = i_final;
                fin_st       = ST_BOUNDARY;
            end
            PH_DATA: begin
                cmd.has_item = 1'b1;
                cmd.kind     = KIND_WRITE;
                cmd.addr     = r_waddr;
                cmd.val      = i_byte;
                n_waddr      = r_waddr + 24'd1;
                n_left       = left_dec;
                fin          = i_final;
                if (left_dec == 16'd0) begin
                    complete = 1'b1;
                    fin_st   = ST_BOUNDARY;
                end else begin
                    fin_st   = ST_TRUNC;
                end
            end
            PH_DONE: begin
                n_phase = PH_DONE;
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase

        n_count    = r_count;
        n_last_end = r_last_end;
        if (complete) begin
            if (r_count != 16'hFFFF) begin
                n_count = r_count + 16'd1;
            end
            n_last_end = {1'b0, r_start} + {9'd0, r_size};
            n_phase    = PH_OFFSET;
            n_idx      = '0;
        end

        if (fin) begin
            n_phase = PH_DONE;
        end
        cmd.has_fin  = fin;
        cmd.status   = fin ? fin_st : ST_EOF;
        cmd.recs     = fin ? n_count : 16'd0;
        cmd.end_addr = fin ? n_last_end : 25'd0;
    end

    assign o_push = accept && (cmd.has_item || cmd.has_fin);
    assign o_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_idx      <= '0;
            r_start    <= '0;
            r_size     <= '0;
            r_left     <= '0;
            r_waddr    <= '0;
            r_count    <= '0;
            r_last_end <= '0;
        end else if (accept) begin
            r_phase    <= n_phase;
            r_idx      <= n_idx;
            r_start    <= n_start;
            r_size     <= n_size;
            r_left     <= n_left;
            r_waddr    <= n_waddr;
            r_count    <= n_count;
            r_last_end <= n_last_end;
        end
    end

    a_done_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DONE) |-> !o_push)
        else $error("push after patch finished");

    a_fin_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_cmd.has_fin) |=> (r_phase == PH_DONE))
        else $error("finish command did not end parsing");

    // a header that ends early leaves its index behind in the done phase
    a_field_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_HEADER && r_phase != PH_DONE) |-> (r_idx < OFF_LEN))
        else $error("field byte index out of range");

endmodule

// ===== rtl/core/ipsp_queue.sv =====
// ----------------------------------------------------------------------------
// IPS patch command queue
// Small FIFO between the byte parser and the result sequencer.
// ----------------------------------------------------------------------------
module ipsp_queue #(
    parameter int DEPTH = ipsp_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ipsp_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output ipsp_pkg::t_cmd o_head,
    output logic           o_empty,
    output logic           o_full
);
    import ipsp_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + PW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count exceeds depth");

endmodule

// ===== rtl/core/ipsp_back.sv =====
// ----------------------------------------------------------------------------
// IPS patch result sequencer
// Expands each queued command into one or two result beats and holds them in
// an output register until the receiver takes them.
// ----------------------------------------------------------------------------
module ipsp_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ipsp_pkg::t_cmd                 i_head,
    input  logic                           i_empty,
    output logic                           o_pop,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [ipsp_pkg::TDATA_W-1:0]   o_m_tdata,
    output logic [1:0]                     o_m_tuser,
    output logic                           o_m_tlast
);
    import ipsp_pkg::*;

    logic        r_valid;
    logic        r_sub;
    logic [1:0]  r_kind;
    logic [23:0] r_addr;
    logic [15:0] r_run;
    logic [7:0]  r_val;
    logic [1:0]  r_status;
    logic [15:0] r_recs;
    logic [24:0] r_end;
    logic        r_last;
    logic        load, emit_item;

    assign load      = (!r_valid || i_m_tready) && !i_empty;
    assign emit_item = i_head.has_item && !r_sub;
    // pop once the last beat of the head entry is loaded
    assign o_pop     = load && !(emit_item && i_head.has_fin);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_sub   <= emit_item && i_head.has_fin;
            end else if (i_m_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (emit_item) begin
                r_kind   <= i_head.kind;
                r_addr   <= i_head.addr;
                r_run    <= i_head.run;
                r_val    <= i_head.val;
                r_status <= ST_EOF;
                r_recs   <= '0;
                r_end    <= '0;
                r_last   <= !i_head.has_fin;
            end else begin
                r_kind   <= KIND_FIN;
                r_addr   <= '0;
                r_run    <= '0;
                r_val    <= '0;
                r_status <= i_head.status;
                r_recs   <= i_head.recs;
                r_end    <= i_head.end_addr;
                r_last   <= 1'b1;
            end
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tuser  = r_kind;
    assign o_m_tlast  = r_last;
    assign o_m_tdata  = {5'd0, r_end, r_recs, r_status, r_val, r_run, r_addr};

    a_fin_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_kind == KIND_FIN) |-> r_last)
        else $error("finish beat without tlast");

    a_split_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub |-> (!i_empty && i_head.has_fin))
        else $error("pending finish lost from queue head");

endmodule

// ===== rtl/core/ips_patch_record_parser.sv =====
// ----------------------------------------------------------------------------
// IPS patch record parser
// Parses an IPS patch byte stream into byte writes, fill runs and a final
// status beat.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side takes one patch byte per beat in s_tdata[7:0]; s_tlast marks the
//   last byte of the patch. Master side gives one result per beat; m_tuser is
//   the kind (write, fill, finished) and m_tlast flags the last result caused
//   by an input byte.
//   A byte that produces results is written into the command queue when it is
//   accepted; its first result is loaded from the queue into the output
//   register as soon as that register is empty or its beat is being taken.
//   Throughput: one byte per cycle sustained while the command queue is not
//   full. The only byte giving two results is the one that finishes the patch;
//   after that all bytes are taken and dropped until reset.
//   The command queue (QUEUE_DEPTH entries) decouples the parser from the
//   output; when the receiver stalls, the parser keeps taking bytes that give
//   no result and stops taking bytes only once the queue is full.
//   Reset (synchronous, active low) returns the parser to the header check and
//   clears the record count and last end address.
// ----------------------------------------------------------------------------
module ips_patch_record_parser #(
    parameter int QUEUE_DEPTH = ipsp_pkg::QUEUE_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    // [7:0] patch_byte
    input  logic [7:0]                   i_s_tdata,
    input  logic                         i_s_tlast,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    // [23:0] target_address, [39:24] run_length, [47:40] byte_value,
    // [49:48] end_status, [65:50] records_seen, [90:66] end_address, [95:91] 0
    output logic [ipsp_pkg::TDATA_W-1:0] o_m_tdata,
    // [1:0] kind
    output logic [1:0]                   o_m_tuser,
    output logic                         o_m_tlast
);
    import ipsp_pkg::*;

    t_cmd push_cmd, head_cmd;
    logic push, pop, q_empty, q_full;

    ipsp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_byte  (i_s_tdata),
        .i_final (i_s_tlast),
        .i_full  (q_full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    ipsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    ipsp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head_cmd),
        .i_empty    (q_empty),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

// ===== bench/ips_patch_record_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// IPS patch parser result checker
// Follows every byte beat taken by the parser, works out the byte writes,
// fill runs and finish beats it must produce, and compares each result beat
// field by field against the oldest one still outstanding.
// ----------------------------------------------------------------------------
module ips_patch_record_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    input  logic                         i_s_tready,
    // [7:0] patch_byte
    input  logic [7:0]                   i_s_tdata,
    input  logic                         i_s_tlast,
    input  logic                         i_m_tvalid,
    input  logic                         i_m_tready,
    // [23:0] target_address, [39:24] run_length, [47:40] byte_value,
    // [49:48] end_status, [65:50] records_seen, [90:66] end_address, [95:91] 0
    input  logic [ipsp_pkg::TDATA_W-1:0] i_m_tdata,
    // [1:0] kind
    input  logic [1:0]                   i_m_tuser,
    input  logic                         i_m_tlast,
    output int                           o_mismatches,
    output int                           o_pending
);

    import ipsp_pkg::*;

    localparam int          MAX_REPORTS = 40;
    localparam logic [39:0] PATCH_TAG   = "PATCH";

    typedef enum logic [2:0] {
        P_HEADER,
        P_OFFSET,
        P_SIZE,
        P_COUNT,
        P_FILL,
        P_DATA,
        P_DONE
    } t_parse_phase;

    typedef struct packed {
        logic [1:0]  kind;
        logic [23:0] addr;
        logic [15:0] run;
        logic [7:0]  val;
        logic [1:0]  status;
        logic [15:0] recs;
        logic [24:0] end_addr;
        logic        last;
    } t_result;

    t_result      expected_q[$];

    t_parse_phase phase;
    logic [2:0]   byte_idx;
    logic [23:0]  rec_start;
    logic [15:0]  rec_size;
    logic [15:0]  left_cnt;
    logic [23:0]  wr_addr;
    logic [15:0]  rec_count;
    logic [24:0]  last_end;

    task automatic note_mismatch(input string msg);
        if (o_mismatches < MAX_REPORTS)
            $display("%0t ns: %s", $time, msg);
        o_mismatches++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            note_mismatch($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    // build the finish beat and stop parsing until reset
    function automatic t_result finished(input logic [1:0] st);
        t_result r;
        r = '0;
        r.kind = KIND_FIN;
        r.status = st;
        r.recs = rec_count;
        r.end_addr = last_end;
        phase = P_DONE;
        return r;
    endfunction

    function automatic void close_record();
        if (rec_count != 16'hFFFF)
            rec_count++;
        last_end = {1'b0, rec_start} + 25'(rec_size);
        phase = P_OFFSET;
        byte_idx = '0;
    endfunction

    task automatic parse_byte(input logic [7:0] b, input logic fin);
        t_result outs[$];
        t_result r;
        case (phase)
            P_HEADER: begin
                if (byte_idx >= HDR_LEN ||
                    b != PATCH_TAG[8 * (int'(HDR_LEN) - 1 - int'(byte_idx)) +: 8]) begin
                    outs.push_back(finished(ST_BAD_HDR));
                end else begin
                    byte_idx++;
                    if (byte_idx == HDR_LEN) begin
                        byte_idx = '0;
                        phase = P_OFFSET;
                        if (fin)
                            outs.push_back(finished(ST_BOUNDARY));
                    end else if (fin) begin
                        outs.push_back(finished(ST_BAD_HDR));
                    end
                end
            end
            P_OFFSET: begin
                rec_start = {rec_start[15:0], b};
                byte_idx++;
                if (byte_idx >= OFF_LEN) begin
                    byte_idx = '0;
                    if (rec_start == EOF_MARK) begin
                        outs.push_back(finished(ST_EOF));
                    end else begin
                        phase = P_SIZE;
                        if (fin)
                            outs.push_back(finished(ST_TRUNC));
                    end
                end else if (fin) begin
                    outs.push_back(finished(ST_TRUNC));
                end
            end
            P_SIZE, P_COUNT: begin
                rec_size = {rec_size[7:0], b};
                byte_idx++;
                if (byte_idx >= SIZE_LEN) begin
                    byte_idx = '0;
                    if (phase == P_COUNT) begin
                        phase = P_FILL;
                    end else if (rec_size == '0) begin
                        phase = P_COUNT;
                    end else begin
                        left_cnt = rec_size;
                        wr_addr = rec_start;
                        phase = P_DATA;
                    end
                end
                if (fin)
                    outs.push_back(finished(ST_TRUNC));
            end
            P_FILL: begin
                r = '0;
                r.kind = KIND_FILL;
                r.addr = rec_start;
                r.run = rec_size;
                r.val = b;
                outs.push_back(r);
                close_record();
                if (fin)
                    outs.push_back(finished(ST_BOUNDARY));
            end
            P_DATA: begin
                r = '0;
                r.kind = KIND_WRITE;
                r.addr = wr_addr;
                r.val = b;
                outs.push_back(r);
                wr_addr++;
                left_cnt--;
                if (left_cnt == '0) begin
                    close_record();
                    if (fin)
                        outs.push_back(finished(ST_BOUNDARY));
                end else if (fin) begin
                    outs.push_back(finished(ST_TRUNC));
                end
            end
            default: begin
                // drop everything after the finish beat
            end
        endcase
        foreach (outs[k]) begin
            r = outs[k];
            r.last = (k == outs.size() - 1);
            expected_q.push_back(r);
        end
    endtask

    task automatic check_result();
        t_result want;
        if (expected_q.size() == 0) begin
            note_mismatch($sformatf("result beat with none pending, kind %0d", i_m_tuser));
        end else begin
            want = expected_q.pop_front();
            compare_field("kind", 32'(i_m_tuser), 32'(want.kind));
            compare_field("target_address", 32'(i_m_tdata[23:0]), 32'(want.addr));
            compare_field("run_length", 32'(i_m_tdata[39:24]), 32'(want.run));
            compare_field("byte_value", 32'(i_m_tdata[47:40]), 32'(want.val));
            compare_field("end_status", 32'(i_m_tdata[49:48]), 32'(want.status));
            compare_field("records_seen", 32'(i_m_tdata[65:50]), 32'(want.recs));
            compare_field("end_address", 32'(i_m_tdata[90:66]), 32'(want.end_addr));
            compare_field("tdata padding", 32'(i_m_tdata[95:91]), 32'd0);
            compare_field("last_in_run", 32'(i_m_tlast), 32'(want.last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_q.delete();
            phase = P_HEADER;
            byte_idx = '0;
            rec_start = '0;
            rec_size = '0;
            left_cnt = '0;
            wr_addr = '0;
            rec_count = '0;
            last_end = '0;
        end else begin
            if (i_s_tvalid && i_s_tready)
                parse_byte(i_s_tdata, i_s_tlast);
            if (i_m_tvalid && i_m_tready)
                check_result();
        end
        o_pending = expected_q.size();
    end

endmodule

// ===== bench/tb_ips_patch_record_parser.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// IPS patch record parser testbench
// Feeds one long patch: a few hand-picked records at the address and value
// extremes, then random write and fill records, closed by an EOF marker, a
// clean end or a cut record, followed by bytes that must be dropped. Both
// stream sides stall at random, and the result side holds off once for a
// long stretch. The checker beside the parser predicts and compares.
// ----------------------------------------------------------------------------
module tb_ips_patch_record_parser;

    import ipsp_pkg::*;

    localparam int          HALF_PERIOD    = 4;
    localparam int          RESET_CYCLES   = 12;
    localparam int          ITEMS          = 1750;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          TAIL_CYCLES    = 16;
    localparam int          TRAILING_BYTES = 16;
    localparam int          TIMEOUT_NS     = 2_000_000;
    localparam logic [39:0] PATCH_TAG      = "PATCH";

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } t_patch_beat;

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata  = '0;
    logic               s_tlast  = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic [1:0]         m_tuser;
    logic               m_tlast;

    int                 mismatches;
    int                 pending;
    int                 recv_idle_pct = 0;
    logic               hold_req      = 1'b0;
    logic               hold_done;
    int                 hold_left;

    t_patch_beat        patch_q[$];

    always #HALF_PERIOD clk = ~clk;

    ips_patch_record_parser i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    ips_patch_record_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    function automatic void push_byte(input logic [7:0] b);
        patch_q.push_back(t_patch_beat'{data: b, fin: 1'b0});
    endfunction

    function automatic void push_be16(input logic [15:0] v);
        push_byte(v[15:8]);
        push_byte(v[7:0]);
    endfunction

    function automatic void push_offset(input logic [23:0] off);
        push_byte(off[23:16]);
        push_byte(off[15:8]);
        push_byte(off[7:0]);
    endfunction

    function automatic void add_fill(input logic [23:0] off, input logic [15:0] cnt,
                                     input logic [7:0] val);
        push_offset(off);
        push_be16(16'h0000);
        push_be16(cnt);
        push_byte(val);
    endfunction

    // flag the newest byte as the end of the patch data
    function automatic void mark_final();
        t_patch_beat beat;
        beat = patch_q.pop_back();
        beat.fin = 1'b1;
        patch_q.push_back(beat);
    endfunction

    // result side: random stalls, plus one long hold-off once asked for
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_req && !hold_done) begin
            m_tready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_tready <= (int'($urandom_range(0, 99)) >= recv_idle_pct);
        end
    end

    initial begin
        int          last_rec;
        int          total;
        int          send_idle;
        int          cut;
        logic [23:0] off;
        logic [15:0] len;

        for (int k = 0; k < int'(HDR_LEN); k++)
            push_byte(PATCH_TAG[8 * (int'(HDR_LEN) - 1 - k) +: 8]);

        // write across the top of the address space, both byte extremes
        push_offset(24'hFFFFFF);
        push_be16(16'd2);
        push_byte(8'h00);
        push_byte(8'hFF);
        // empty fill run, then the longest one where the end needs 25 bits
        add_fill(24'h000000, 16'h0000, 8'h5A);
        add_fill(24'hFFFFFF, 16'hFFFF, 8'hA5);

        last_rec = 0;
        while (patch_q.size() < ITEMS) begin
            last_rec = patch_q.size();
            if ($urandom_range(0, 7) == 0)
                off = 24'hFFFFFF - 24'($urandom_range(0, 8));
            else
                off = 24'($urandom);
            if (off == EOF_MARK)
                off = ~off;
            if ($urandom_range(0, 4) == 0) begin
                case ($urandom_range(0, 5))
                    0:       len = 16'h0000;
                    1:       len = 16'hFFFF;
                    default: len = 16'($urandom);
                endcase
                add_fill(off, len, 8'($urandom));
            end else begin
                if ($urandom_range(0, 9) == 0)
                    len = 16'($urandom_range(7, 48));
                else
                    len = 16'($urandom_range(1, 6));
                push_offset(off);
                push_be16(len);
                repeat (len) push_byte(8'($urandom));
            end
        end

        case ($urandom_range(0, 2))
            0: begin
                // EOF marker ends the patch whether or not it is flagged final
                push_offset(EOF_MARK);
                if ($urandom_range(0, 1) != 0)
                    mark_final();
            end
            1: mark_final();
            default: begin
                // cut the newest record anywhere short of its last byte
                cut = $urandom_range(last_rec, patch_q.size() - 2);
                while (patch_q.size() > cut + 1)
                    void'(patch_q.pop_back());
                mark_final();
            end
        endcase

        // bytes after the finish must be swallowed without results
        repeat (TRAILING_BYTES)
            patch_q.push_back(t_patch_beat'{data: 8'($urandom), fin: 1'($urandom)});

        total = patch_q.size();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < total; i++) begin
            if (3 * i < total) begin
                send_idle = 21;
                recv_idle_pct <= 61;
            end else if (3 * i < 2 * total) begin
                send_idle = 61;
                recv_idle_pct <= 21;
            end else begin
                send_idle = 0;
                recv_idle_pct <= 0;
                hold_req <= 1'b1;
            end
            while (int'($urandom_range(0, 99)) < send_idle) begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata <= patch_q[i].data;
            s_tlast <= patch_q[i].fin;
            @(posedge clk);
            while (!s_tready) @(posedge clk);
        end
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Mismatches found");
        $finish;
    end

endmodule
